/* hw/rtl/bilinear_upsample_2x_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 2x bilinear upsampler
// Immediate-consequence and next-cycle property checks, clocked on clk and
// disabled while rst_n is low. Defining NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_UPSAMPLE_2X_MACROS_SVH
`define BILINEAR_UPSAMPLE_2X_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BU2X_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BU2X_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BU2X_ASSERT_IMPL(label, ante, cons, msg)
`define BU2X_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hw/rtl/bu2x_pkg.sv */
// ----------------------------------------------------------------------------
// bu2x_pkg
// Shared constants and types of the 2x bilinear upsampler.
// ----------------------------------------------------------------------------
package bu2x_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int COORD_BITS    = 11;
  localparam int CFG_BITS      = 11;
  localparam int CFG_ADDR_BITS = 3;
  localparam int BUS_BITS      = 32;

  localparam logic [CFG_BITS-1:0] SRC_WIDTH_RST  = 11'd17;
  localparam logic [CFG_BITS-1:0] SRC_HEIGHT_RST = 11'd5;

  typedef enum logic {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } reg_idx_t;

  // Result slots of one request, in the order they leave the block.
  typedef enum logic [1:0] {
    SLOT_CENTRE = 2'd0,
    SLOT_UPPER  = 2'd1,
    SLOT_LEFT   = 2'd2,
    SLOT_SELF   = 2'd3
  } slot_t;

endpackage

/* hw/rtl/bu2x_ram.sv */
// ----------------------------------------------------------------------------
// bu2x_ram
// Generic single-write, single-read synchronous RAM with registered read.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module bu2x_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bilinear_upsample_2x.sv */
// ----------------------------------------------------------------------------
// bilinear_upsample_2x
// Corner-aligned 2x bilinear upsampler for a raster-order stream of samples,
// producing the exact interpolated grid scaled by four.
//
//   Channel  | Direction | Handshake          | Payload
//   in_      | request   | in_valid/in_stall  | in_sample
//   out_     | result    | out_valid/out_stall| value, row, col, run/frame marks
//   config   | APB-style | psel/penable       | src_width, src_height
//
// One result leaves per cycle on the single result port unless out_stall
// holds it; a request gives one result at the first column of the first
// source row, two elsewhere in that row and at the first column below it,
// four otherwise. Each passes stage 1 and stage 2 before the result register.
// The line store is read and written at the same address in the accept
// cycle; no clearing pass follows reset.
// A stalled result register holds the pipeline and, through it, in_stall.
// ----------------------------------------------------------------------------
`include "bilinear_upsample_2x_macros.svh"

module bilinear_upsample_2x #(
  parameter int MAX_WIDTH   = bu2x_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bu2x_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = bu2x_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_BITS+1:0]          out_value,
  output logic [bu2x_pkg::COORD_BITS-1:0]        out_row,
  output logic [bu2x_pkg::COORD_BITS-1:0]        out_col,
  output logic                                   out_run_last,
  output logic                                   out_frame_end,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bu2x_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [bu2x_pkg::BUS_BITS-1:0]          pwdata,
  output logic [bu2x_pkg::BUS_BITS-1:0]          prdata,
  output logic                                   pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int VB  = SAMPLE_BITS + 2;
  localparam int CB  = bu2x_pkg::COORD_BITS;
  localparam int CFB = bu2x_pkg::CFG_BITS;

  // Configuration registers.
  logic [CFB-1:0]     src_width_r, src_height_r;
  logic               cfg_wr;
  bu2x_pkg::reg_idx_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = bu2x_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= bu2x_pkg::SRC_WIDTH_RST;
      src_height_r <= bu2x_pkg::SRC_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        bu2x_pkg::REG_SRC_WIDTH:  src_width_r  <= pwdata[CFB-1:0];
        bu2x_pkg::REG_SRC_HEIGHT: src_height_r <= pwdata[CFB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      bu2x_pkg::REG_SRC_WIDTH:  prdata = bu2x_pkg::BUS_BITS'(src_width_r);
      bu2x_pkg::REG_SRC_HEIGHT: prdata = bu2x_pkg::BUS_BITS'(src_height_r);
      default:                  prdata = '0;
    endcase
  end

  // Clamped frame extent, held as the last column and last row index.
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;

  always_comb begin
    if (32'(src_width_r) > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else if (src_width_r < CFB'(2)) begin
      last_col = CW'(1);
    end else begin
      last_col = CW'(src_width_r - CFB'(1));
    end
    if (32'(src_height_r) > 32'(MAX_HEIGHT)) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else if (src_height_r < CFB'(2)) begin
      last_row = RW'(1);
    end else begin
      last_row = RW'(src_height_r - CFB'(1));
    end
  end

  // Position of the next request.
  logic          in_acc;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          col_wrap, row_wrap;

  assign in_acc   = in_valid & ~in_stall;
  assign col_wrap = (col_r == last_col);
  assign row_wrap = (row_r == last_row);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store: the read returns the previous row's sample at this column
  // while the new sample is written over it.
  logic [SAMPLE_BITS-1:0] ram_rdata;

  bu2x_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col_r),
    .wdata (in_sample),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // Stage 1: request waiting for its line store data.
  logic                          s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [CW-1:0]                 s1_col_r;
  logic [RW-1:0]                 s1_row_r;
  logic                          s1_flast_r;
  logic                          s1_move;
  logic signed [SAMPLE_BITS-1:0] up_in;
  logic [3:0]                    pend_in;

  // Stage 2: request whose results are being sent.
  logic                          s2_valid_r, s2_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] s2_sample_r, s2_up_r, s2_left_r, s2_ul_r;
  logic [CW-1:0]                 s2_col_r;
  logic [RW-1:0]                 s2_row_r;
  logic                          s2_flast_r;
  logic [3:0]                    s2_pend_r, s2_pend_nxt;
  logic                          s2_free;

  logic signed [SAMPLE_BITS-1:0] left_r, ul_r;

  logic                          emit;
  bu2x_pkg::slot_t               slot;
  logic [3:0]                    pend_left;
  logic                          slot_last;
  logic                          out_valid_r, out_valid_nxt;

  assign s1_move  = s1_valid_r & s2_free;
  assign in_stall = s1_valid_r & ~s2_free;
  assign up_in    = (s1_row_r != '0) ? $signed(ram_rdata) : '0;
  assign pend_in  = {1'b1, s1_col_r != '0, s1_row_r != '0,
                     (s1_row_r != '0) && (s1_col_r != '0)};

  assign s1_valid_nxt = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample;
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_flast_r  <= col_wrap & row_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
    end else if (s1_move) begin
      left_r <= s1_sample_r;
      ul_r   <= up_in;
    end
  end

  always_comb begin
    if (s2_pend_r[0]) begin
      slot = bu2x_pkg::SLOT_CENTRE;
    end else if (s2_pend_r[1]) begin
      slot = bu2x_pkg::SLOT_UPPER;
    end else if (s2_pend_r[2]) begin
      slot = bu2x_pkg::SLOT_LEFT;
    end else begin
      slot = bu2x_pkg::SLOT_SELF;
    end
  end

  assign pend_left = s2_pend_r & ~(4'b0001 << slot);
  assign slot_last = (pend_left == 4'b0000);
  assign emit      = s2_valid_r & (~out_valid_r | ~out_stall);
  assign s2_free   = ~s2_valid_r | (emit & slot_last);

  assign s2_valid_nxt = s1_move ? 1'b1 : (s2_free ? 1'b0 : s2_valid_r);
  assign s2_pend_nxt  = s1_move ? pend_in : (emit ? pend_left : s2_pend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_pend_r  <= '0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      s2_pend_r  <= s2_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_sample_r <= s1_sample_r;
      s2_up_r     <= up_in;
      s2_left_r   <= left_r;
      s2_ul_r     <= ul_r;
      s2_col_r    <= s1_col_r;
      s2_row_r    <= s1_row_r;
      s2_flast_r  <= s1_flast_r;
    end
  end

  // Result value and coordinates for the selected slot.
  logic signed [VB-1:0] s_x, up_x, lf_x, ul_x, val;
  logic [CB-1:0]        row_even, row_odd, col_even, col_odd;
  logic [CB-1:0]        res_row, res_col;

  assign s_x  = $signed({{2{s2_sample_r[SAMPLE_BITS-1]}}, s2_sample_r});
  assign up_x = $signed({{2{s2_up_r[SAMPLE_BITS-1]}}, s2_up_r});
  assign lf_x = $signed({{2{s2_left_r[SAMPLE_BITS-1]}}, s2_left_r});
  assign ul_x = $signed({{2{s2_ul_r[SAMPLE_BITS-1]}}, s2_ul_r});

  assign row_even = CB'({s2_row_r, 1'b0});
  assign row_odd  = row_even - CB'(1);
  assign col_even = CB'({s2_col_r, 1'b0});
  assign col_odd  = col_even - CB'(1);

  always_comb begin
    case (slot)
      bu2x_pkg::SLOT_CENTRE: begin
        val     = (ul_x + up_x) + (lf_x + s_x);
        res_row = row_odd;
        res_col = col_odd;
      end
      bu2x_pkg::SLOT_UPPER: begin
        val     = (up_x + s_x) <<< 1;
        res_row = row_odd;
        res_col = col_even;
      end
      bu2x_pkg::SLOT_LEFT: begin
        val     = (lf_x + s_x) <<< 1;
        res_row = row_even;
        res_col = col_odd;
      end
      default: begin
        val     = s_x <<< 2;
        res_row = row_even;
        res_col = col_even;
      end
    endcase
  end

  // Result register.
  assign out_valid_nxt = emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value     <= val;
      out_row       <= res_row;
      out_col       <= res_col;
      out_run_last  <= slot_last;
      out_frame_end <= slot_last & s2_flast_r;
    end
  end

  `BU2X_ASSERT_IMPL(a_pend_nonzero, s2_valid_r, s2_pend_r != 4'b0000, "empty held request")
  `BU2X_ASSERT_IMPL(a_frame_end_last, out_valid_r && out_frame_end, out_run_last, "frame mark")
  `BU2X_ASSERT_NEXT(a_accept_fills, in_acc, s1_valid_r, "request lost")
  `BU2X_ASSERT_IMPL(a_col_range, s1_valid_r || s2_valid_r || in_acc, col_r <= last_col, "overrun")
  `BU2X_ASSERT_NEXT(a_last_frees, emit && slot_last && !s1_move, !s2_valid_r, "stage two kept")

endmodule
